FILE: rtl/core/hdlc_frame_receiver_macros.svh
// Assertion macros used by the checker file of the frame receiver.
`ifndef HDLC_FRAME_RECEIVER_MACROS_SVH
`define HDLC_FRAME_RECEIVER_MACROS_SVH

// Property checked at every rising clock edge, switched off while reset is low.
`define HFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define HFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/hfr_pkg.sv
`timescale 1ns / 1ps

package hfr_pkg;

    // Frame limits
    localparam int FRAME_BUFFER_BYTES = 512;
    localparam int MAX_ADDR_BYTES     = 3;

    // Byte codes
    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [3:0] FORMAT_TYPE = 4'hA;

    // Status codes
    localparam logic [3:0] ST_IGNORED    = 4'd0;
    localparam logic [3:0] ST_ACCEPTED   = 4'd1;
    localparam logic [3:0] ST_FRAME_DONE = 4'd2;
    localparam logic [3:0] ST_BAD_FORMAT = 4'd3;
    localparam logic [3:0] ST_DST_ADDR   = 4'd4;
    localparam logic [3:0] ST_SRC_ADDR   = 4'd5;
    localparam logic [3:0] ST_HCS        = 4'd6;
    localparam logic [3:0] ST_FCS        = 4'd7;
    localparam logic [3:0] ST_END_FLAG   = 4'd8;
    localparam logic [3:0] ST_OVERFLOW   = 4'd9;

    // Item handed from the front queue to the frame engine
    typedef struct packed {
        logic       is_flag;
        logic [7:0] data;
    } t_rx_item;

endpackage

FILE: rtl/core/hdlc_frame_receiver.sv
`timescale 1ns / 1ps

// HDLC type-3 frame receiver. Takes one received byte per item on s_axis and
// returns one result per byte on m_axis: a status code in tuser and the frame
// length and address lengths known so far in tdata. A byte is taken every
// clock while results are drained; a byte passes the two-entry input queue and
// then the frame engine, whose CRC-16/X.25 update and position compare are
// combinational and feed the result register, which sets the rate of one byte
// per clock. Both sides may stall freely; the input queue and the result
// register decouple them. No start-up pass is needed after reset.
module hdlc_frame_receiver #(
    parameter int FRAME_BUFFER_BYTES = hfr_pkg::FRAME_BUFFER_BYTES,
    parameter int MAX_ADDR_BYTES     = hfr_pkg::MAX_ADDR_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [11:0] frame_length, [15:12] dest_addr_len,
                                         // [19:16] src_addr_len, [23:20] zero
    output logic [3:0]  m_axis_tuser     // [3:0] status
);

    hfr_pkg::t_rx_item item;
    logic              item_valid;
    logic              item_ready;

    hfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_item_valid  (item_valid),
        .i_item_ready  (item_ready),
        .o_item        (item)
    );

    hfr_engine #(
        .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES),
        .MAX_ADDR_BYTES     (MAX_ADDR_BYTES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .o_item_ready  (item_ready),
        .i_item        (item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: rtl/core/hfr_front.sv
`timescale 1ns / 1ps

// Accepts received bytes, tags flag bytes and holds them in a two-entry queue.
module hfr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,    // [7:0] rx_byte
    output logic              o_item_valid,
    input  logic              i_item_ready,
    output hfr_pkg::t_rx_item o_item
);

    hfr_pkg::t_rx_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign s_axis_tready = (r_count != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_item_valid  = (r_count != 2'd0);
    assign pop           = o_item_valid && i_item_ready;
    assign o_item        = r_mem[r_rd_ptr];

    // Queue storage, tagged on the way in
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr].data    <= s_axis_tdata;
            r_mem[r_wr_ptr].is_flag <= (s_axis_tdata == hfr_pkg::FLAG_BYTE);
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/hfr_engine.sv
`timescale 1ns / 1ps

// Frame tracker: position, lengths, running CRC and checks, one byte per cycle
// while results drain, followed by the result register.
module hfr_engine #(
    parameter int FRAME_BUFFER_BYTES = hfr_pkg::FRAME_BUFFER_BYTES,
    parameter int MAX_ADDR_BYTES     = hfr_pkg::MAX_ADDR_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  hfr_pkg::t_rx_item i_item,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,    // [11:0] frame_length, [15:12] dest_addr_len,
                                               // [19:16] src_addr_len, [23:20] zero
    output logic [3:0]        m_axis_tuser     // [3:0] status
);

    // CRC-16/X.25 over one byte, reflected polynomial
    function automatic logic [15:0] crc_x25_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        end
        return c;
    endfunction

    logic [12:0] r_pos,  n_pos;
    logic [11:0] r_len,  n_len;
    logic [3:0]  r_dst,  n_dst;
    logic [3:0]  r_src,  n_src;
    logic [12:0] r_scan, n_scan;
    logic [3:0]  r_fhn,  n_fhn;
    logic [15:0] r_crc,  n_crc;
    logic [15:0] r_hist, n_hist;
    logic [7:0]  r_prev, n_prev;

    logic        r_out_valid;
    logic [3:0]  r_out_status;
    logic [11:0] r_out_len;
    logic [3:0]  r_out_dst;
    logic [3:0]  r_out_src;

    logic        take;
    logic        v_idle;
    logic [3:0]  v_status;
    logic [12:0] v_p;
    logic [12:0] v_scan;
    logic [15:0] v_got;
    logic [15:0] v_want;
    logic [7:0]  d;

    assign o_item_ready = !r_out_valid || m_axis_tready;
    assign take         = i_item_valid && o_item_ready;
    assign d            = i_item.data;

    // Next frame state for the byte at the queue head
    always_comb begin
        n_pos    = r_pos;
        n_len    = r_len;
        n_dst    = r_dst;
        n_src    = r_src;
        n_scan   = r_scan;
        n_fhn    = r_fhn;
        n_crc    = r_crc;
        n_hist   = r_hist;
        n_prev   = r_prev;
        v_idle   = 1'b0;
        v_status = hfr_pkg::ST_ACCEPTED;
        v_p      = r_pos;
        v_scan   = r_scan;
        v_got    = {d, r_prev};
        v_want   = ~r_hist;

        if (r_pos == 13'd0 && !i_item.is_flag) begin
            v_status = hfr_pkg::ST_IGNORED;
        end else begin
            // previous frame finished, or buffer full: restart on this byte
            if ((r_len != 12'd0 && {1'b0, r_pos} >= ({2'b00, r_len} + 14'd2))
                || (r_pos >= 13'(FRAME_BUFFER_BYTES))) begin
                if (r_pos >= 13'(FRAME_BUFFER_BYTES)
                    && !(r_len != 12'd0 && {1'b0, r_pos} >= ({2'b00, r_len} + 14'd2)))
                begin
                    v_status = hfr_pkg::ST_OVERFLOW;
                end
                n_pos  = '0;
                n_len  = '0;
                n_dst  = '0;
                n_src  = '0;
                n_scan = '0;
                n_fhn  = '0;
                v_p    = '0;
            end

            if (v_p == 13'd1 && i_item.is_flag) begin
                // repeated opening flag
                v_status = hfr_pkg::ST_IGNORED;
            end else begin
                n_prev = d;
                if (v_p == 13'd0) begin
                    n_crc  = 16'hFFFF;
                    n_hist = 16'hFFFF;
                end else begin
                    n_hist = r_crc;
                    n_crc  = crc_x25_byte(r_crc, d);
                end
                v_p   = v_p + 13'd1;
                n_pos = v_p;

                if (v_p == 13'd1) begin
                    // opening flag stored
                end else if (v_p == 13'd2) begin
                    n_fhn = d[3:0];
                    if (d[7:4] != hfr_pkg::FORMAT_TYPE) begin
                        v_idle   = 1'b1;
                        v_status = hfr_pkg::ST_BAD_FORMAT;
                    end
                end else if (v_p == 13'd3) begin
                    n_len = {n_fhn, d};
                end else if (n_dst == 4'd0) begin
                    v_scan = n_scan + 13'd1;
                    n_scan = v_scan;
                    if (d[0]) begin
                        if (v_scan > 13'(MAX_ADDR_BYTES)) begin
                            v_idle   = 1'b1;
                            v_status = hfr_pkg::ST_DST_ADDR;
                        end else begin
                            n_dst  = (v_scan > 13'd15) ? 4'd15 : v_scan[3:0];
                            n_scan = '0;
                        end
                    end
                end else if (n_src == 4'd0) begin
                    v_scan = n_scan + 13'd1;
                    n_scan = v_scan;
                    if (d[0]) begin
                        if (v_scan > 13'(MAX_ADDR_BYTES)) begin
                            v_idle   = 1'b1;
                            v_status = hfr_pkg::ST_SRC_ADDR;
                        end else begin
                            n_src  = (v_scan > 13'd15) ? 4'd15 : v_scan[3:0];
                            n_scan = '0;
                        end
                    end
                end else if (v_p == ({9'd0, n_dst} + {9'd0, n_src} + 13'd6)) begin
                    if (v_got != v_want) begin
                        v_idle   = 1'b1;
                        v_status = hfr_pkg::ST_HCS;
                    end
                end else if (v_p == ({1'b0, n_len} + 13'd1)) begin
                    if (v_got != v_want) begin
                        v_idle   = 1'b1;
                        v_status = hfr_pkg::ST_FCS;
                    end
                end else if (v_p == ({1'b0, n_len} + 13'd2)) begin
                    if (i_item.is_flag) begin
                        v_status = hfr_pkg::ST_FRAME_DONE;
                    end else begin
                        v_idle   = 1'b1;
                        v_status = hfr_pkg::ST_END_FLAG;
                    end
                end
            end

            // error: drop the frame
            if (v_idle) begin
                n_pos  = '0;
                n_len  = '0;
                n_dst  = '0;
                n_src  = '0;
                n_scan = '0;
                n_fhn  = '0;
            end
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_len  <= '0;
            r_dst  <= '0;
            r_src  <= '0;
            r_scan <= '0;
            r_fhn  <= '0;
            r_crc  <= 16'hFFFF;
            r_hist <= 16'hFFFF;
            r_prev <= '0;
        end else if (take) begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_dst  <= n_dst;
            r_src  <= n_src;
            r_scan <= n_scan;
            r_fhn  <= n_fhn;
            r_crc  <= n_crc;
            r_hist <= n_hist;
            r_prev <= n_prev;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_status <= v_status;
            r_out_len    <= n_len;
            r_out_dst    <= n_dst;
            r_out_src    <= n_src;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {4'b0000, r_out_src, r_out_dst, r_out_len};

endmodule

FILE: rtl/core/hfr_checker.sv
`timescale 1ns / 1ps

`include "hdlc_frame_receiver_macros.svh"

// Port-level checks on the frame receiver's results.
module hfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    logic err_status;

    // error codes leave the frame dropped, with nothing known about it
    assign err_status = (m_axis_tuser != hfr_pkg::ST_IGNORED)
                     && (m_axis_tuser != hfr_pkg::ST_ACCEPTED)
                     && (m_axis_tuser != hfr_pkg::ST_FRAME_DONE);

    `HFR_ASSERT_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")

    `HFR_ASSERT(a_result_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    `HFR_ASSERT(a_src_after_dst, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[19:16] != 4'd0) |-> (m_axis_tdata[15:12] != 4'd0), "source length without destination length")

    `HFR_ASSERT(a_error_clears, i_clk, i_rst_n, m_axis_tvalid && err_status |-> (m_axis_tdata == 24'd0), "frame state not cleared on error")

endmodule

bind hdlc_frame_receiver hfr_checker u_hfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
